// File: design/ufc_pkg.sv
// Shared types and constants for the union-find connectivity engine.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ufc_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int SIZE_W     = NODE_W + 1;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [SIZE_W-1:0] tsize_t;

    // Opcode values carried in s_tuser
    localparam logic OP_UNION = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Engine to store: one parent read, one parent write, one size read, one size write
    typedef struct packed {
        node_t  par_raddr;
        logic   par_we;
        node_t  par_waddr;
        node_t  par_wdata;
        node_t  sz_raddr;
        logic   sz_we;
        node_t  sz_waddr;
        tsize_t sz_wdata;
    } store_req_t;

    // Store to engine: registered read data and clear-pass status
    typedef struct packed {
        logic   busy;
        node_t  par_rdata;
        tsize_t sz_rdata;
    } store_rsp_t;

    // Engine to top level
    typedef struct packed {
        logic idle;
        logic res_valid;
        logic connected;
        logic merged;
    } eng_status_t;

endpackage

`default_nettype wire

// File: design/union_find_connectivity_top.sv
// Top level of the union-find connectivity engine: stream ports and result register.
// Depends on ufc_pkg, ufc_store and ufc_engine.
//
//  Channel   Dir  Signals                         Contents
//  s_*       in   tvalid tready tdata[23:0] tuser  request: node_a, node_b; tuser = opcode
//  m_*       out  tvalid tready tdata[7:0]         result: connected, merged
//
//  Once accepted, a request walks from node_a, then from node_b, to the roots; a union of
//  unconnected nodes then reads both tree sizes and links the roots. Walk depths are at
//  most log2 of the node count with size-weighted linking. Only unions halve the path:
//  each halving step passes through S_GP, which makes the grandparent the node's parent.
//  After reset a clearing pass initializes both memories; s_tready stays low until it ends.
//  A result waits in the output register; a new request may be taken meanwhile.
`default_nettype none

module union_find_connectivity_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [9:0] node_a, [19:10] node_b, [23:20] zero
    input  wire         s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata    // [0] connected, [1] merged, [7:2] zero
);
    import ufc_pkg::*;

    store_req_t  req;
    store_rsp_t  rsp;
    eng_status_t status;

    logic        start;
    logic        res_ready;
    logic        m_tvalid_reg;
    logic [1:0]  m_flags_reg;

    assign s_tready  = status.idle && !rsp.busy;
    assign start     = s_tvalid && s_tready;
    assign res_ready = !m_tvalid_reg || m_tready;

    ufc_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ufc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (s_tuser),
        .node_a    (s_tdata[NODE_W-1:0]),
        .node_b    (s_tdata[2*NODE_W-1:NODE_W]),
        .res_ready (res_ready),
        .rsp       (rsp),
        .req       (req),
        .status    (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (status.res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.res_valid && res_ready)
        begin
            m_flags_reg <= {status.merged, status.connected};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_flags_reg};

endmodule

`default_nettype wire

// File: design/ufc_store.sv
// Parent and tree-size memories with a post-reset clearing pass.
// Depends on ufc_pkg.
`default_nettype none

module ufc_store (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ufc_pkg::store_req_t req,
    output ufc_pkg::store_rsp_t rsp
);
    import ufc_pkg::*;

    localparam node_t CLR_LAST = node_t'(NODE_COUNT - 1);

    node_t  par_mem [NODE_COUNT];
    tsize_t sz_mem  [NODE_COUNT];

    node_t  par_rdata_reg;
    tsize_t sz_rdata_reg;
    logic   clr_busy_reg;
    node_t  clr_cnt_reg;

    logic   par_we;
    node_t  par_waddr;
    node_t  par_wdata;
    logic   sz_we;
    node_t  sz_waddr;
    tsize_t sz_wdata;

    // Clearing pass owns the write ports until every entry is initialized
    always_comb
    begin
        if (clr_busy_reg)
        begin
            par_we    = 1'b1;
            par_waddr = clr_cnt_reg;
            par_wdata = clr_cnt_reg;
            sz_we     = 1'b1;
            sz_waddr  = clr_cnt_reg;
            sz_wdata  = tsize_t'(1);
        end
        else
        begin
            par_we    = req.par_we;
            par_waddr = req.par_waddr;
            par_wdata = req.par_wdata;
            sz_we     = req.sz_we;
            sz_waddr  = req.sz_waddr;
            sz_wdata  = req.sz_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + node_t'(1);
            if (clr_cnt_reg == CLR_LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        par_rdata_reg <= par_mem[req.par_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sz_we)
        begin
            sz_mem[sz_waddr] <= sz_wdata;
        end
        sz_rdata_reg <= sz_mem[req.sz_raddr];
    end

    assign rsp.busy      = clr_busy_reg;
    assign rsp.par_rdata = par_rdata_reg;
    assign rsp.sz_rdata  = sz_rdata_reg;

endmodule

`default_nettype wire

// File: design/ufc_engine.sv
// Sequencer for root walks (path halving on unions), size compare and link.
// Depends on ufc_pkg; drives the ports of ufc_store.
`default_nettype none

module ufc_engine (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire                  op,
    input  ufc_pkg::node_t       node_a,
    input  ufc_pkg::node_t       node_b,
    input  wire                  res_ready,
    input  ufc_pkg::store_rsp_t  rsp,
    output ufc_pkg::store_req_t  req,
    output ufc_pkg::eng_status_t status
);
    import ufc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_GP   = 3'd2;
    localparam logic [2:0] S_SZA  = 3'd3;
    localparam logic [2:0] S_SZB  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       op_reg, op_next;
    logic       second_reg, second_next;
    logic       conn_reg, conn_next;
    logic       merged_reg, merged_next;
    node_t      b_reg, b_next;
    node_t      cur_reg, cur_next;
    node_t      ra_reg, ra_next;
    node_t      rb_reg, rb_next;
    tsize_t     sa_reg, sa_next;
    tsize_t     sum;

    assign sum = sa_reg + rsp.sz_rdata;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        second_next = second_reg;
        conn_next   = conn_reg;
        merged_next = merged_reg;
        b_next      = b_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        sa_next     = sa_reg;

        req = '0;
        req.par_raddr = cur_reg;
        req.sz_raddr  = ra_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    b_next      = node_b;
                    cur_next    = node_a;
                    second_next = 1'b0;
                    merged_next = 1'b0;
                    req.par_raddr = node_a;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                if (rsp.par_rdata == cur_reg)
                begin
                    if (!second_reg)
                    begin
                        // First root found: start the walk from node b
                        ra_next       = cur_reg;
                        cur_next      = b_reg;
                        second_next   = 1'b1;
                        req.par_raddr = b_reg;
                    end
                    else
                    begin
                        rb_next   = cur_reg;
                        conn_next = (ra_reg == cur_reg);
                        if (op_reg == OP_UNION && ra_reg != cur_reg)
                        begin
                            req.sz_raddr = ra_reg;
                            state_next   = S_SZA;
                        end
                        else
                        begin
                            state_next = S_RES;
                        end
                    end
                end
                else
                begin
                    req.par_raddr = rsp.par_rdata;
                    if (op_reg == OP_UNION)
                    begin
                        state_next = S_GP;
                    end
                    else
                    begin
                        cur_next = rsp.par_rdata;
                    end
                end
            end
            S_GP:
            begin
                // Halve: point cur at its grandparent and continue from there
                req.par_we    = 1'b1;
                req.par_waddr = cur_reg;
                req.par_wdata = rsp.par_rdata;
                req.par_raddr = rsp.par_rdata;
                cur_next      = rsp.par_rdata;
                state_next    = S_CHK;
            end
            S_SZA:
            begin
                sa_next      = rsp.sz_rdata;
                req.sz_raddr = rb_reg;
                state_next   = S_SZB;
            end
            S_SZB:
            begin
                req.par_we  = 1'b1;
                req.sz_we   = 1'b1;
                req.sz_wdata = sum;
                if (sa_reg < rsp.sz_rdata)
                begin
                    req.par_waddr = ra_reg;
                    req.par_wdata = rb_reg;
                    req.sz_waddr  = rb_reg;
                end
                else
                begin
                    req.par_waddr = rb_reg;
                    req.par_wdata = ra_reg;
                    req.sz_waddr  = ra_reg;
                end
                merged_next = 1'b1;
                state_next  = S_RES;
            end
            S_RES:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        second_reg <= second_next;
        conn_reg   <= conn_next;
        merged_reg <= merged_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        sa_reg     <= sa_next;
    end

    assign status.idle      = (state_reg == S_IDLE);
    assign status.res_valid = (state_reg == S_RES);
    assign status.connected = conn_reg;
    assign status.merged    = merged_reg;

endmodule

`default_nettype wire
